@@ design/ipcm_pkg.sv @@
// Package for the IPv4 text CIDR matcher.
// Holds the shared constants, register indexes, character codes, types and the
// CIDR compare function. It depends on nothing else.
package ipcm_pkg;

    localparam int unsigned LP_MAX_ENTRIES = 6;
    localparam int unsigned LP_CFG_IDX_W   = 3;
    localparam int unsigned LP_CFG_DATA_W  = 38;
    localparam int unsigned LP_COUNT_W     = 3;
    localparam int unsigned LP_ADDR_W      = 32;
    localparam int unsigned LP_PLEN_W      = 6;
    localparam int unsigned LP_CHAR_W      = 8;
    localparam int unsigned LP_OCTET_W     = 9;
    localparam int unsigned LP_EARLIER_W   = 24;

    localparam logic [LP_CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [LP_CFG_IDX_W-1:0] REG_CIDR_FIRST  = 3'd1;

    localparam logic [LP_CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [LP_CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [LP_CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [LP_CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0]            LAST_OCTET_POS = 2'd3;
    localparam logic [LP_OCTET_W-1:0] OCTET_SAT      = 9'd256;
    localparam logic [LP_PLEN_W-1:0]  PLEN_MAX       = 6'd32;

    typedef struct packed {
        logic [LP_PLEN_W-1:0] plen;
        logic [LP_ADDR_W-1:0] net;
    } t_cidr_entry;

    typedef struct packed {
        logic                 good;
        logic [LP_ADDR_W-1:0] addr;
    } t_parse_res;

    function automatic logic cidr_hit(input t_cidr_entry entry,
                                      input logic [LP_ADDR_W-1:0] addr);
        logic [LP_ADDR_W-1:0] mask;
        mask = ~({LP_ADDR_W{1'b1}} >> entry.plen);
        return (entry.plen <= PLEN_MAX) && (((entry.net ^ addr) & mask) == '0);
    endfunction

endpackage

@@ design/ipcm_ifs.sv @@
// Channel interfaces for the IPv4 text CIDR matcher: address text in,
// match result out, and the configuration write channel.
// Depends on ipcm_pkg for the field widths.
interface ipcm_text_if;
    import ipcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [LP_CHAR_W-1:0] addr_char;
    logic                 addr_end;

    modport source (output valid, output addr_char, output addr_end, input ready);
    modport sink   (input valid, input addr_char, input addr_end, output ready);
endinterface

interface ipcm_result_if;
    import ipcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 trusted;
    logic                 well_formed;
    logic [LP_ADDR_W-1:0] packed_address;

    modport source (output valid, output trusted, output well_formed,
                    output packed_address, input ready);
    modport sink   (input valid, input trusted, input well_formed,
                    input packed_address, output ready);
endinterface

interface ipcm_cfg_if;
    import ipcm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [LP_CFG_IDX_W-1:0]  index;
    logic [LP_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/ipcm_parse.sv @@
// Dotted-decimal parser: holds the per-address parse state and folds in one
// character per transaction, giving the parse result for a final character.
// Depends on ipcm_pkg.
module ipcm_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [ipcm_pkg::LP_CHAR_W-1:0] i_char,
    input  logic                          i_end,
    output ipcm_pkg::t_parse_res          o_res
);
    import ipcm_pkg::*;

    logic [1:0]              r_pos,     n_pos;
    logic [LP_OCTET_W-1:0]   r_val,     n_val;
    logic                    r_digit,   n_digit;
    logic                    r_minus,   n_minus;
    logic                    r_mal,     n_mal;
    logic [LP_EARLIER_W-1:0] r_earlier, n_earlier;

    logic [11:0] w_sum;
    logic        w_cur_ok;
    logic        w_new_ok;

    assign w_sum = {r_val, 3'b000} + {2'b00, r_val, 1'b0} + {8'h00, i_char[3:0]};
    assign w_cur_ok = r_digit && !r_val[LP_OCTET_W-1] && (!r_minus || r_val == '0);

    always_comb begin
        n_pos     = r_pos;
        n_val     = r_val;
        n_digit   = r_digit;
        n_minus   = r_minus;
        n_mal     = r_mal;
        n_earlier = r_earlier;
        case (i_char) inside
            [CHAR_ZERO:CHAR_NINE]: begin
                n_val   = (w_sum > 12'(OCTET_SAT)) ? OCTET_SAT : w_sum[LP_OCTET_W-1:0];
                n_digit = 1'b1;
            end
            CHAR_MINUS: begin
                if (r_digit || r_minus) begin
                    n_mal = 1'b1;
                end
                n_minus = 1'b1;
            end
            CHAR_DOT: begin
                if (!w_cur_ok || r_pos == LAST_OCTET_POS) begin
                    n_mal = 1'b1;
                end else begin
                    n_earlier = {r_earlier[LP_EARLIER_W-9:0], r_val[7:0]};
                    n_pos     = r_pos + 2'd1;
                end
                n_val   = '0;
                n_digit = 1'b0;
                n_minus = 1'b0;
            end
            default: begin
                n_mal = 1'b1;
            end
        endcase
    end

    assign w_new_ok = n_digit && !n_val[LP_OCTET_W-1] && (!n_minus || n_val == '0);

    always_comb begin
        o_res.good = !n_mal && (n_pos == LAST_OCTET_POS) && w_new_ok;
        o_res.addr = o_res.good ? {n_earlier, n_val[7:0]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end)) begin
            r_pos     <= '0;
            r_val     <= '0;
            r_digit   <= 1'b0;
            r_minus   <= 1'b0;
            r_mal     <= 1'b0;
            r_earlier <= '0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_val     <= n_val;
            r_digit   <= n_digit;
            r_minus   <= n_minus;
            r_mal     <= n_mal;
            r_earlier <= n_earlier;
        end
    end

endmodule

@@ design/ipcm_match.sv @@
// CIDR match: compares one address against every active network entry.
// Depends on ipcm_pkg for the entry type and the compare function.
module ipcm_match (
    input  logic [ipcm_pkg::LP_ADDR_W-1:0]  i_addr,
    input  logic [ipcm_pkg::LP_COUNT_W-1:0] i_count,
    input  ipcm_pkg::t_cidr_entry           i_entry [ipcm_pkg::LP_MAX_ENTRIES],
    output logic                            o_hit
);
    import ipcm_pkg::*;

    logic [LP_MAX_ENTRIES-1:0] w_hits;

    always_comb begin
        for (int i = 0; i < LP_MAX_ENTRIES; i++) begin
            w_hits[i] = (LP_COUNT_W'(i) < i_count) && cidr_hit(i_entry[i], i_addr);
        end
    end

    assign o_hit = |w_hits;

endmodule

@@ design/ipv4_text_cidr_matcher_unit.sv @@
// Top level of the IPv4 text CIDR matcher. It takes one address character
// per transaction and gives one result for each character marked final.
// Depends on ipcm_pkg, the channel interfaces, ipcm_parse and ipcm_match.
//
// The block accepts one character in every cycle while the output is not held
// off. A character passes an input register, is parsed on its way to a parse
// register, and the CIDR compare against up to six entries runs on its way to
// the output register, where the result for a final character is offered;
// results wait there while the output is held off.
// Configuration writes are always ready and are meant for idle periods only.
module ipv4_text_cidr_matcher_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipcm_text_if.sink     i_text,
    ipcm_cfg_if.sink      i_cfg,
    ipcm_result_if.source o_result
);
    import ipcm_pkg::*;

    logic [LP_COUNT_W-1:0] r_entry_count;
    t_cidr_entry           r_entry [LP_MAX_ENTRIES];

    logic                 r_a_valid;
    logic [LP_CHAR_W-1:0] r_a_char;
    logic                 r_a_end;

    logic                 r_b_valid;
    t_parse_res           r_b_res;

    logic                 r_o_valid;
    logic                 r_o_trusted;
    logic                 r_o_well_formed;
    logic [LP_ADDR_W-1:0] r_o_addr;

    logic       w_o_free;
    logic       w_b_free;
    logic       w_take;
    logic       w_b_move;
    logic       w_in_acc;
    logic       w_cfg_we;
    logic       w_hit;
    t_parse_res w_res;

    assign w_o_free = !r_o_valid || o_result.ready;
    assign w_b_free = !r_b_valid || w_o_free;
    assign w_take   = r_a_valid && w_b_free;
    assign w_b_move = r_b_valid && w_o_free;
    assign w_in_acc = i_text.valid && i_text.ready;
    assign w_cfg_we = i_cfg.valid && i_cfg.ready;

    assign i_text.ready = !r_a_valid || w_take;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            for (int i = 0; i < LP_MAX_ENTRIES; i++) begin
                r_entry[i] <= '0;
            end
        end else if (w_cfg_we) begin
            if (i_cfg.index == REG_ENTRY_COUNT) begin
                r_entry_count <= i_cfg.data[LP_COUNT_W-1:0];
            end
            for (int i = 0; i < LP_MAX_ENTRIES; i++) begin
                if (i_cfg.index == REG_CIDR_FIRST + LP_CFG_IDX_W'(i)) begin
                    r_entry[i] <= i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_char <= i_text.addr_char;
            r_a_end  <= i_text.addr_end;
        end
    end

    ipcm_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_char  (r_a_char),
        .i_end   (r_a_end),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= (w_take && r_a_end) || (r_b_valid && !w_o_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_a_end) begin
            r_b_res <= w_res;
        end
    end

    ipcm_match u_match (
        .i_addr  (r_b_res.addr),
        .i_count (r_entry_count),
        .i_entry (r_entry),
        .o_hit   (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_b_move || (r_o_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_o_trusted     <= r_b_res.good && w_hit;
            r_o_well_formed <= r_b_res.good;
            r_o_addr        <= r_b_res.addr;
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.trusted        = r_o_trusted;
    assign o_result.well_formed    = r_o_well_formed;
    assign o_result.packed_address = r_o_addr;

endmodule
